/* sv/sus_pkg.sv */
// ----------------------------------------------------------------------------
// Sorted unique set engine package
// Shared constants, command and status codes, cell control types.
// ----------------------------------------------------------------------------
package sus_pkg;

  localparam int DEF_CAPACITY    = 16;
  localparam int DEF_VALUE_WIDTH = 32;

  localparam int CMD_W   = 2;
  localparam int IN_VAL_W = 32;
  localparam int STAT_W  = 3;
  localparam int POS_W   = 5;
  localparam int OCC_W   = 5;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 2'd0,
    CMD_SEARCH = 2'd1,
    CMD_DELETE = 2'd2,
    CMD_CLEAR  = 2'd3
  } sus_cmd_t;

  typedef enum logic [STAT_W-1:0] {
    ST_INSERTED  = 3'd0,
    ST_DUPLICATE = 3'd1,
    ST_FULL      = 3'd2,
    ST_FOUND     = 3'd3,
    ST_ABSENT    = 3'd4,
    ST_DELETED   = 3'd5,
    ST_CLEARED   = 3'd6
  } sus_status_t;

  typedef enum logic {
    FSM_IDLE = 1'b0,
    FSM_UPD  = 1'b1
  } sus_state_t;

  typedef enum logic [1:0] {
    OP_HOLD   = 2'd0,
    OP_INSERT = 2'd1,
    OP_DELETE = 2'd2
  } sus_op_t;

  typedef struct packed {
    logic    cmp_en;
    sus_op_t op;
  } sus_ctl_t;

endpackage

/* sv/sus_cell.sv */
// ----------------------------------------------------------------------------
// Sorted unique set cell
// Holds one entry, compares it with the incoming key and shifts with its
// neighbours on insert and delete.
// ----------------------------------------------------------------------------
module sus_cell #(
  parameter int VALUE_WIDTH = sus_pkg::DEF_VALUE_WIDTH,
  parameter int CAPACITY    = sus_pkg::DEF_CAPACITY,
  parameter int CELL_IDX    = 0
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  sus_pkg::sus_ctl_t                  ctl,
  input  logic [$clog2(CAPACITY+1)-1:0]      count,
  input  logic [VALUE_WIDTH-1:0]             key_cmp,
  input  logic [VALUE_WIDTH-1:0]             key_wr,
  input  logic                               lt_left,
  input  logic [VALUE_WIDTH-1:0]             key_left,
  input  logic [VALUE_WIDTH-1:0]             key_right,
  output logic                               lt_r,
  output logic                               eq_r,
  output logic [VALUE_WIDTH-1:0]             key_r
);
  import sus_pkg::*;

  localparam int CW = $clog2(CAPACITY+1);

  logic                   valid;
  logic                   lt_nxt;
  logic                   eq_nxt;
  logic [VALUE_WIDTH-1:0] key_nxt;

  assign valid  = (count > CW'(CELL_IDX));
  assign lt_nxt = ctl.cmp_en ? (valid && (key_r < key_cmp)) : lt_r;
  assign eq_nxt = ctl.cmp_en ? (valid && (key_r == key_cmp)) : eq_r;

  // Cells below the slot hold; on delete the rest take the right neighbour's
  // entry, on insert the first takes the new key and the rest the left one's.
  always_comb begin
    key_nxt = key_r;
    case (ctl.op)
      OP_INSERT: begin
        if (!lt_r) begin
          key_nxt = lt_left ? key_wr : key_left;
        end
      end
      OP_DELETE: begin
        if (!lt_r) begin
          key_nxt = key_right;
        end
      end
      default: key_nxt = key_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lt_r <= 1'b0;
      eq_r <= 1'b0;
    end else begin
      lt_r <= lt_nxt;
      eq_r <= eq_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
  end

endmodule

/* sv/sorted_unique_set_engine.sv */
// A request is taken only while idle; the cells register the compare flags,
// then the result is registered and the row of cells shifts once the output
// is free, so no new request is taken before the last result is registered.
// Reset: synchronous, active low; the set is empty and no result is pending.
// Entries carry no reset; of the set's contents only the occupancy count is cleared.
// ----------------------------------------------------------------------------
// Sorted unique set engine
// Keeps an ascending set of unique signed values in a row of cells and
// serves insert, search, delete and clear requests.
// ----------------------------------------------------------------------------
module sorted_unique_set_engine #(
  parameter int CAPACITY    = sus_pkg::DEF_CAPACITY,
  parameter int VALUE_WIDTH = sus_pkg::DEF_VALUE_WIDTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] value
  input  logic [1:0]  in_tuser,   // [1:0] command
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [4:0] position, [9:5] occupancy, [15:10] zero
  output logic [2:0]  out_tuser   // [2:0] status
);
  import sus_pkg::*;

  localparam int CW = $clog2(CAPACITY+1);

  sus_state_t             state_r, state_nxt;
  sus_cmd_t               cmd_r;
  logic [VALUE_WIDTH-1:0] key_r;
  logic [CW-1:0]          count_r, count_nxt;
  logic                   out_tvalid_r;
  logic [STAT_W-1:0]      status_r, status_nxt;
  logic [POS_W-1:0]       pos_r, pos_nxt;

  logic                   in_acc;
  logic                   out_free;
  logic                   upd_go;
  sus_ctl_t               ctl;
  logic signed [VALUE_WIDTH-1:0] val_ext;
  logic [VALUE_WIDTH-1:0] key_in;
  logic                   hit;
  logic [CW-1:0]          slot;
  logic [CW+POS_W-1:0]    slot_ext;
  logic [CW+OCC_W-1:0]    occ_ext;

  logic                   lt_w    [CAPACITY];
  logic                   eq_w    [CAPACITY];
  logic [VALUE_WIDTH-1:0] ckey_w  [CAPACITY];

  assign in_tready = (state_r == FSM_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign out_free  = !out_tvalid_r || out_tready;
  assign upd_go    = (state_r == FSM_UPD) && out_free;

  // Offset binary: flipping the sign bit makes unsigned order match signed.
  assign val_ext = VALUE_WIDTH'(signed'(in_tdata));
  assign key_in  = {~val_ext[VALUE_WIDTH-1], val_ext[VALUE_WIDTH-2:0]};

  genvar gi;
  generate
    for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
      logic                   lt_left;
      logic [VALUE_WIDTH-1:0] key_left;
      logic [VALUE_WIDTH-1:0] key_right;
      if (gi == 0) begin : g_first
        assign lt_left  = 1'b1;
        assign key_left = '0;
      end else begin : g_mid
        assign lt_left  = lt_w[gi-1];
        assign key_left = ckey_w[gi-1];
      end
      if (gi == CAPACITY-1) begin : g_last
        assign key_right = ckey_w[gi];
      end else begin : g_inner
        assign key_right = ckey_w[gi+1];
      end
      sus_cell #(
        .VALUE_WIDTH(VALUE_WIDTH),
        .CAPACITY   (CAPACITY),
        .CELL_IDX   (gi)
      ) u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (ctl),
        .count    (count_r),
        .key_cmp  (key_in),
        .key_wr   (key_r),
        .lt_left  (lt_left),
        .key_left (key_left),
        .key_right(key_right),
        .lt_r     (lt_w[gi]),
        .eq_r     (eq_w[gi]),
        .key_r    (ckey_w[gi])
      );
    end
  endgenerate

  // The less-than flags form a thermometer, so the slot is the one cell
  // where the run of set flags ends, or CAPACITY when every flag is set.
  always_comb begin
    hit  = 1'b0;
    slot = lt_w[CAPACITY-1] ? CW'(CAPACITY) : '0;
    for (int i = 0; i < CAPACITY; i++) begin
      hit = hit | eq_w[i];
      if (!lt_w[i] && ((i == 0) || lt_w[(i == 0) ? 0 : i-1])) begin
        slot = slot | CW'(i);
      end
    end
  end

  assign slot_ext = {{POS_W{1'b0}}, slot};

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      FSM_IDLE: if (in_acc) state_nxt = FSM_UPD;
      FSM_UPD:  if (out_free) state_nxt = FSM_IDLE;
      default:  state_nxt = FSM_IDLE;
    endcase
  end

  // Outputs of the sequencer: cell control, count and result.
  always_comb begin
    ctl.cmp_en = in_acc;
    ctl.op     = OP_HOLD;
    count_nxt  = count_r;
    status_nxt = status_r;
    pos_nxt    = pos_r;
    if (upd_go) begin
      pos_nxt = '0;
      case (cmd_r)
        CMD_INSERT: begin
          pos_nxt = slot_ext[POS_W-1:0];
          if (hit) begin
            status_nxt = ST_DUPLICATE;
          end else if (count_r == CW'(CAPACITY)) begin
            status_nxt = ST_FULL;
          end else begin
            status_nxt = ST_INSERTED;
            ctl.op     = OP_INSERT;
            count_nxt  = count_r + 1'b1;
          end
        end
        CMD_SEARCH: begin
          if (hit) begin
            status_nxt = ST_FOUND;
            pos_nxt    = slot_ext[POS_W-1:0];
          end else begin
            status_nxt = ST_ABSENT;
          end
        end
        CMD_DELETE: begin
          if (hit) begin
            status_nxt = ST_DELETED;
            pos_nxt    = slot_ext[POS_W-1:0];
            ctl.op     = OP_DELETE;
            count_nxt  = count_r - 1'b1;
          end else begin
            status_nxt = ST_ABSENT;
          end
        end
        default: begin
          status_nxt = ST_CLEARED;
          count_nxt  = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= FSM_IDLE;
      count_r      <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      if (upd_go) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      cmd_r <= sus_cmd_t'(in_tuser);
      key_r <= key_in;
    end
    status_r <= status_nxt;
    pos_r    <= pos_nxt;
  end

  assign occ_ext    = {{OCC_W{1'b0}}, count_r};
  assign out_tvalid = out_tvalid_r;
  assign out_tuser  = status_r;
  assign out_tdata  = {6'b0, occ_ext[OCC_W-1:0], pos_r};

endmodule

/* sv/sus_checker.sv */
// ----------------------------------------------------------------------------
// Sorted unique set engine checker
// Port-level assertions on the request and result channels.
// ----------------------------------------------------------------------------
module sus_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata,
  input logic [2:0]  out_tuser
);
  import sus_pkg::*;

  // A held result must not change until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // One request at a time: the engine is busy in the cycle after a request.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("request accepted while busy");

  // The compare flags are registered first, then the result once the output is
  // free; an older result still held keeps the valid high meanwhile.
  a_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> ##1 out_tvalid)
    else $error("no result after request");

  // Clear empties the set and reports position zero.
  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == ST_CLEARED) |-> (out_tdata[9:0] == 10'd0))
    else $error("clear result not empty");

  // A missed key reports position zero.
  a_absent: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == ST_ABSENT) |-> (out_tdata[4:0] == 5'd0))
    else $error("absent result with non-zero position");

endmodule

bind sorted_unique_set_engine sus_checker u_sus_checker (.*);
